// File: src/tdir_pkg.sv
// Shared types, constants and helpers for the two-dot IR position estimator.
// Used by every module of the block; no dependencies of its own.
package tdir_pkg;

	localparam int FRAME_WIDTH  = 1024;
	localparam int FRAME_HEIGHT = 768;

	localparam int PIX_W      = 10;
	localparam int HALF_W     = 12;
	localparam int ABS_W      = 11;
	localparam int D2_W       = 22;
	localparam int SQRT_W     = 40;
	localparam int SQRT_STEPS = 20;
	localparam int DIST_W     = 20;
	localparam int DIV_STEPS  = 32;
	localparam int CAM_W      = 24;
	localparam int PROD_W     = 35;
	localparam int MAG_W      = 32;
	localparam int PART_W     = 51;
	localparam int P_W        = 57;
	localparam int OMAG_W     = 32;
	localparam int ROT_W      = 49;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_DOTS  = 2'd1;
	localparam logic [1:0] ST_COINCIDE = 2'd2;

	localparam logic [2:0] REG_DEPTH_RATIO   = 3'd0;
	localparam logic [2:0] REG_MM_PER_PIXEL  = 3'd1;
	localparam logic [2:0] REG_CAM_TO_DOTS   = 3'd2;
	localparam logic [2:0] REG_SCREEN_OFFSET = 3'd3;
	localparam logic [2:0] REG_PITCH_COSINE  = 3'd4;
	localparam logic [2:0] REG_PITCH_SINE    = 3'd5;

	localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
	localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;
	localparam logic signed [ROT_W-1:0] ROUND_HALF = 49'sd16384;

	// Sideband that travels with a beat down the pipeline.
	typedef struct packed {
		logic [1:0]        status;
		logic              x_neg;
		logic              z_pos;
		logic [PROD_W-1:0] ax_mpp;
		logic [PROD_W-1:0] az_mpp;
		logic [MAG_W-1:0]  mag;
	} tag_t;

	typedef struct packed {
		logic [31:0]        depth_ratio;
		logic [23:0]        mm_per_pixel;
		logic [23:0]        cam_mm;
		logic signed [23:0] screen_offset;
		logic signed [15:0] cosine;
		logic signed [15:0] sine;
	} cfg_t;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		if (v > SAT_MAX) begin
			sat32 = 32'sh7FFF_FFFF;
		end else if (v < SAT_MIN) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

endpackage

// File: src/tdir_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on tdir_pkg for widths and the sideband type.
module tdir_sqrt (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               valid_i,
	input  tdir_pkg::tag_t                     tag_i,
	input  logic [tdir_pkg::SQRT_W-1:0]        v_i,
	output logic                               valid_o,
	output tdir_pkg::tag_t                     tag_o,
	output logic [tdir_pkg::DIST_W-1:0]        root_o
);

	logic                        vld_s [tdir_pkg::SQRT_STEPS+1];
	logic [tdir_pkg::SQRT_W-1:0] rem_s [tdir_pkg::SQRT_STEPS+1];
	logic [tdir_pkg::SQRT_W-1:0] res_s [tdir_pkg::SQRT_STEPS+1];
	tdir_pkg::tag_t              tag_s [tdir_pkg::SQRT_STEPS+1];

	assign vld_s[0] = valid_i;
	assign rem_s[0] = v_i;
	assign res_s[0] = '0;
	assign tag_s[0] = tag_i;

	for (genvar k = 0; k < tdir_pkg::SQRT_STEPS; k++) begin : g_step
		localparam logic [tdir_pkg::SQRT_W-1:0] STEP_BIT =
			tdir_pkg::SQRT_W'(1) << (2 * (tdir_pkg::SQRT_STEPS - 1 - k));
		logic [tdir_pkg::SQRT_W-1:0] trial;
		logic                        ge;

		assign trial = res_s[k] + STEP_BIT;
		assign ge    = rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? rem_s[k] - trial : rem_s[k];
				res_s[k+1] <= ge ? (res_s[k] >> 1) + STEP_BIT : res_s[k] >> 1;
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign valid_o = vld_s[tdir_pkg::SQRT_STEPS];
	assign tag_o   = tag_s[tdir_pkg::SQRT_STEPS];
	assign root_o  = res_s[tdir_pkg::SQRT_STEPS][tdir_pkg::DIST_W-1:0];

endmodule

// File: src/tdir_div.sv
// Pipelined restoring divider for depth: ratio scaled by 256 over dot distance.
// Depends on tdir_pkg; writes the clamped quotient into the sideband.
module tdir_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_i,
	input  tdir_pkg::tag_t                tag_i,
	input  logic [tdir_pkg::DIST_W-1:0]   dist_i,
	input  logic [31:0]                   ratio_i,
	output logic                          valid_o,
	output tdir_pkg::tag_t                tag_o
);

	logic                        vld_s [tdir_pkg::DIV_STEPS+1];
	logic [tdir_pkg::DIST_W-1:0] rem_s [tdir_pkg::DIV_STEPS+1];
	logic [tdir_pkg::DIST_W-1:0] d_s   [tdir_pkg::DIV_STEPS+1];
	logic [tdir_pkg::MAG_W-1:0]  nq_s  [tdir_pkg::DIV_STEPS+1];
	tdir_pkg::tag_t              tag_s [tdir_pkg::DIV_STEPS+1];
	logic [tdir_pkg::MAG_W-1:0]  quo;

	// The distance is at least 256, so the top eight quotient bits are always zero.
	assign vld_s[0] = valid_i;
	assign rem_s[0] = {12'd0, ratio_i[31:24]};
	assign nq_s[0]  = {ratio_i[23:0], 8'd0};
	assign d_s[0]   = dist_i;
	assign tag_s[0] = tag_i;

	for (genvar k = 0; k < tdir_pkg::DIV_STEPS; k++) begin : g_step
		logic [tdir_pkg::DIST_W:0] t;
		logic [tdir_pkg::DIST_W:0] diff;
		logic                      ge;

		assign t    = {rem_s[k], nq_s[k][tdir_pkg::MAG_W-1]};
		assign ge   = t >= {1'b0, d_s[k]};
		assign diff = t - {1'b0, d_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[tdir_pkg::DIST_W-1:0] : t[tdir_pkg::DIST_W-1:0];
				nq_s[k+1]  <= {nq_s[k][tdir_pkg::MAG_W-2:0], ge};
				d_s[k+1]   <= d_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign quo     = nq_s[tdir_pkg::DIV_STEPS];
	assign valid_o = vld_s[tdir_pkg::DIV_STEPS];

	always_comb begin
		tag_o     = tag_s[tdir_pkg::DIV_STEPS];
		tag_o.mag = quo[tdir_pkg::MAG_W-1] ? 32'h8000_0000 : quo;
	end

endmodule

// File: src/tdir_offset.sv
// Lateral and height offset magnitudes: offset times scale times depth over
// the calibration distance, two lanes in parallel. Depends on tdir_pkg.
module tdir_offset (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_i,
	input  tdir_pkg::tag_t                tag_i,
	input  logic [tdir_pkg::CAM_W-1:0]    cam_i,
	output logic                          valid_o,
	output tdir_pkg::tag_t                tag_o,
	output logic [tdir_pkg::OMAG_W-1:0]   x_mag_o,
	output logic [tdir_pkg::OMAG_W-1:0]   z_mag_o
);

	logic                         vld_s1;
	logic                         vld_s2;
	tdir_pkg::tag_t               tag_s1;
	tdir_pkg::tag_t               tag_s2;
	logic [tdir_pkg::PART_W-1:0]  pl_s1 [2];
	logic [tdir_pkg::PART_W-1:0]  ph_s1 [2];
	logic [tdir_pkg::P_W-1:0]     p_s2  [2];

	logic                         vld_d [tdir_pkg::DIV_STEPS+1];
	tdir_pkg::tag_t               tag_d [tdir_pkg::DIV_STEPS+1];
	logic [tdir_pkg::CAM_W-1:0]   rem_d [2][tdir_pkg::DIV_STEPS+1];
	logic [tdir_pkg::MAG_W-1:0]   nq_d  [2][tdir_pkg::DIV_STEPS+1];
	logic                         ovf_d [2][tdir_pkg::DIV_STEPS+1];

	logic                         vld_s3;
	tdir_pkg::tag_t               tag_s3;
	logic [tdir_pkg::OMAG_W-1:0]  mag_s3 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= valid_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_d[tdir_pkg::DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= tag_i;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_d[tdir_pkg::DIV_STEPS];
		end
	end

	assign vld_d[0] = vld_s2;
	assign tag_d[0] = tag_s2;

	for (genvar k = 0; k < tdir_pkg::DIV_STEPS; k++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_d[k+1] <= 1'b0;
			end else if (en) begin
				vld_d[k+1] <= vld_d[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_d[k+1] <= tag_d[k];
			end
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [tdir_pkg::PROD_W-1:0] a;
		logic [66:0]                 sum;

		assign a = (l == 0) ? tag_i.ax_mpp : tag_i.az_mpp;
		// The full product reaches 66 bits, so it is built from two 16-bit halves of depth.
		assign sum = 67'(pl_s1[l]) + {ph_s1[l], 16'd0};

		// Magnitudes stop at 2^31; the rotation stage applies the final signed limits.
		always_ff @(posedge clk) begin
			if (en) begin
				pl_s1[l]  <= tdir_pkg::PART_W'(a) * tdir_pkg::PART_W'(tag_i.mag[15:0]);
				ph_s1[l]  <= tdir_pkg::PART_W'(a) * tdir_pkg::PART_W'(tag_i.mag[31:16]);
				p_s2[l]   <= sum[65:9];
				mag_s3[l] <= (ovf_d[l][tdir_pkg::DIV_STEPS] ||
					nq_d[l][tdir_pkg::DIV_STEPS][tdir_pkg::MAG_W-1]) ?
					{1'b1, {(tdir_pkg::OMAG_W-1){1'b0}}} :
					nq_d[l][tdir_pkg::DIV_STEPS];
			end
		end

		// A quotient of 2^32 or more shows up as the high part already reaching the divisor.
		assign rem_d[l][0] = p_s2[l][55:32];
		assign nq_d[l][0]  = p_s2[l][31:0];
		assign ovf_d[l][0] = p_s2[l][56:32] >= {1'b0, cam_i};

		for (genvar k = 0; k < tdir_pkg::DIV_STEPS; k++) begin : g_step
			logic [tdir_pkg::CAM_W:0] t;
			logic [tdir_pkg::CAM_W:0] diff;
			logic                     ge;

			assign t    = {rem_d[l][k], nq_d[l][k][tdir_pkg::MAG_W-1]};
			assign ge   = t >= {1'b0, cam_i};
			assign diff = t - {1'b0, cam_i};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_d[l][k+1] <= ge ? diff[tdir_pkg::CAM_W-1:0] : t[tdir_pkg::CAM_W-1:0];
					nq_d[l][k+1]  <= {nq_d[l][k][tdir_pkg::MAG_W-2:0], ge};
					ovf_d[l][k+1] <= ovf_d[l][k];
				end
			end
		end
	end

	assign valid_o = vld_s3;
	assign tag_o   = tag_s3;
	assign x_mag_o = mag_s3[0];
	assign z_mag_o = mag_s3[1];

endmodule

// File: src/tdir_rotate.sv
// Pitch rotation, screen offset and final saturation; last stage is the output register.
// Depends on tdir_pkg for the sideband, config struct and saturation helper.
module tdir_rotate (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_i,
	input  tdir_pkg::tag_t                tag_i,
	input  logic [tdir_pkg::OMAG_W-1:0]   x_mag_i,
	input  logic [tdir_pkg::OMAG_W-1:0]   z_mag_i,
	input  tdir_pkg::cfg_t                cfg_i,
	output logic                          valid_o,
	output logic [1:0]                    status_o,
	output logic signed [31:0]            pos_x_o,
	output logic signed [31:0]            pos_y_o,
	output logic signed [31:0]            pos_z_o
);

	logic signed [31:0]                 x0;
	logic signed [31:0]                 z0;
	logic signed [32:0]                 y0;
	logic signed [32:0]                 mag_sd;
	logic signed [32:0]                 x_neg_v;
	logic [30:0]                        x_pos;
	logic [30:0]                        z_lim;
	logic signed [15:0]                 cosv;
	logic signed [15:0]                 sinv;
	logic signed [23:0]                 soff;

	logic                               vld_s1;
	logic                               vld_s2;
	logic                               vld_s3;
	logic [1:0]                         status_s1;
	logic [1:0]                         status_s2;
	logic [1:0]                         status_s3;
	logic signed [31:0]                 x_s1;
	logic signed [31:0]                 x_s2;
	logic signed [tdir_pkg::ROT_W-1:0]  cy_s1;
	logic signed [tdir_pkg::ROT_W-1:0]  sz_s1;
	logic signed [tdir_pkg::ROT_W-1:0]  sy_s1;
	logic signed [tdir_pkg::ROT_W-1:0]  cz_s1;
	logic signed [tdir_pkg::ROT_W-1:0]  vy;
	logic signed [tdir_pkg::ROT_W-1:0]  vz;
	logic signed [33:0]                 rz;
	logic signed [33:0]                 ry_s2;
	logic signed [35:0]                 rzo_s2;
	logic signed [31:0]                 px_s3;
	logic signed [31:0]                 py_s3;
	logic signed [31:0]                 pz_s3;

	assign cosv   = cfg_i.cosine;
	assign sinv   = cfg_i.sine;
	assign soff   = cfg_i.screen_offset;
	assign mag_sd = $signed({1'b0, tag_i.mag});
	assign y0     = -mag_sd;

	// Only a negative X may reach -2^31; every other offset stops at 2^31 - 1.
	assign x_pos   = x_mag_i[31] ? '1 : x_mag_i[30:0];
	assign z_lim   = z_mag_i[31] ? '1 : z_mag_i[30:0];
	assign x_neg_v = -$signed({1'b0, x_mag_i});
	assign x0      = tag_i.x_neg ? $signed(x_neg_v[31:0]) : $signed({1'b0, x_pos});
	assign z0      = tag_i.z_pos ? $signed({1'b0, z_lim}) : -$signed({1'b0, z_lim});

	// Rounding adds one half and then shifts arithmetically, which floors in both signs.
	assign vy = cy_s1 + sz_s1 + tdir_pkg::ROUND_HALF;
	assign vz = sy_s1 + cz_s1 + tdir_pkg::ROUND_HALF;
	assign rz = vz[48:15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= valid_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_s1 <= tag_i.status;
			x_s1      <= x0;
			cy_s1     <= tdir_pkg::ROT_W'(cosv) * tdir_pkg::ROT_W'(y0);
			sz_s1     <= tdir_pkg::ROT_W'(sinv) * tdir_pkg::ROT_W'(z0);
			sy_s1     <= tdir_pkg::ROT_W'(sinv) * tdir_pkg::ROT_W'(mag_sd);
			cz_s1     <= tdir_pkg::ROT_W'(cosv) * tdir_pkg::ROT_W'(z0);

			status_s2 <= status_s1;
			x_s2      <= x_s1;
			ry_s2     <= vy[48:15];
			rzo_s2    <= 36'(rz) + 36'(soff);

			status_s3 <= status_s2;
			if (status_s2 == tdir_pkg::ST_OK) begin
				px_s3 <= x_s2;
				py_s3 <= tdir_pkg::sat32(36'(ry_s2));
				pz_s3 <= tdir_pkg::sat32(rzo_s2);
			end else begin
				px_s3 <= '0;
				py_s3 <= '0;
				pz_s3 <= '0;
			end
		end
	end

	assign valid_o  = vld_s3;
	assign status_o = status_s3;
	assign pos_x_o  = px_s3;
	assign pos_y_o  = py_s3;
	assign pos_z_o  = pz_s3;

endmodule

// File: src/two_dot_ir_position_estimator_unit.sv
// Top level of the two-dot IR position estimator: config registers, front end
// and the pipeline chain. Depends on tdir_pkg and all tdir_* modules.
//
// Usage:
// - Input channel: one beat carries both dot positions and their seen flags.
//   A beat is taken when in_valid is high and in_stall is low.
// - Output channel: one beat per input beat, in order: status and the
//   Q24.8 position. Taken when out_valid is high and out_stall is low.
// - Config channel: cfg_ready is always high; cfg_index selects the register
//   (depth ratio, mm per pixel, camera-to-dots distance, screen offset,
//   pitch cosine, pitch sine). Other indexes are ignored. Write only while
//   the pipeline is empty.
// - A beat passes through 2 front-end stages, 20 square-root stages,
//   32 depth-divider stages, 35 stages of offset multiply and divide and
//   3 rotation stages. Throughput is one beat per cycle when not stalled,
//   set by the one-bit-per-stage square root and dividers.
// - While a result sits at the output and out_stall is high, the whole
//   pipeline holds and in_stall is high; nothing is lost or repeated.
// - Reset empties the pipeline and loads the config registers with their
//   defaults; there is no clearing pass.
module two_dot_ir_position_estimator_unit (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic [9:0]         dot_a_x,
	input  logic [9:0]         dot_a_y,
	input  logic               dot_a_seen,
	input  logic [9:0]         dot_b_x,
	input  logic [9:0]         dot_b_y,
	input  logic               dot_b_seen,

	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	tdir_pkg::cfg_t cfg_q;
	tdir_pkg::cfg_t cfg_eff;
	logic           en;

	logic signed [tdir_pkg::HALF_W-1:0] dxh;
	logic signed [tdir_pkg::HALF_W-1:0] dyh;
	logic signed [tdir_pkg::ABS_W-1:0]  ddx;
	logic signed [tdir_pkg::ABS_W-1:0]  ddy;
	logic [1:0]                         st_in;

	logic                               vld_s1;
	logic                               vld_s2;
	logic signed [tdir_pkg::ABS_W-1:0]  ddx_s1;
	logic signed [tdir_pkg::ABS_W-1:0]  ddy_s1;
	logic [tdir_pkg::ABS_W-1:0]         adx_s1;
	logic [tdir_pkg::ABS_W-1:0]         ady_s1;
	logic                               x_neg_s1;
	logic                               z_pos_s1;
	logic [1:0]                         status_s1;
	logic [tdir_pkg::D2_W-1:0]          d2_s2;
	tdir_pkg::tag_t                     tag_s2;

	logic                               sq_valid;
	tdir_pkg::tag_t                     sq_tag;
	logic [tdir_pkg::DIST_W-1:0]        sq_root;
	logic                               dv_valid;
	tdir_pkg::tag_t                     dv_tag;
	logic                               of_valid;
	tdir_pkg::tag_t                     of_tag;
	logic [tdir_pkg::OMAG_W-1:0]        of_x_mag;
	logic [tdir_pkg::OMAG_W-1:0]        of_z_mag;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.depth_ratio   <= 32'd0;
			cfg_q.mm_per_pixel  <= 24'd65536;
			cfg_q.cam_mm        <= 24'd256;
			cfg_q.screen_offset <= 24'sd0;
			cfg_q.cosine        <= 16'sd32767;
			cfg_q.sine          <= 16'sd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tdir_pkg::REG_DEPTH_RATIO:   cfg_q.depth_ratio   <= cfg_data;
				tdir_pkg::REG_MM_PER_PIXEL:  cfg_q.mm_per_pixel  <= cfg_data[23:0];
				tdir_pkg::REG_CAM_TO_DOTS:   cfg_q.cam_mm        <= cfg_data[23:0];
				tdir_pkg::REG_SCREEN_OFFSET: cfg_q.screen_offset <= cfg_data[23:0];
				tdir_pkg::REG_PITCH_COSINE:  cfg_q.cosine        <= cfg_data[15:0];
				tdir_pkg::REG_PITCH_SINE:    cfg_q.sine          <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// A zero calibration distance divides as if it were one.
	always_comb begin
		cfg_eff = cfg_q;
		if (cfg_q.cam_mm == '0) begin
			cfg_eff.cam_mm = 24'd1;
		end
	end

	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	assign ddx = tdir_pkg::ABS_W'(dot_a_x) - tdir_pkg::ABS_W'(dot_b_x);
	assign ddy = tdir_pkg::ABS_W'(dot_a_y) - tdir_pkg::ABS_W'(dot_b_y);
	assign dxh = tdir_pkg::HALF_W'(dot_a_x) + tdir_pkg::HALF_W'(dot_b_x)
		- tdir_pkg::HALF_W'(tdir_pkg::FRAME_WIDTH);
	assign dyh = tdir_pkg::HALF_W'(tdir_pkg::FRAME_HEIGHT)
		- tdir_pkg::HALF_W'(dot_a_y) - tdir_pkg::HALF_W'(dot_b_y);

	always_comb begin
		if (!(dot_a_seen && dot_b_seen)) begin
			st_in = tdir_pkg::ST_NO_DOTS;
		end else if (dot_a_x == dot_b_x && dot_a_y == dot_b_y) begin
			st_in = tdir_pkg::ST_COINCIDE;
		end else begin
			st_in = tdir_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ddx_s1    <= ddx;
			ddy_s1    <= ddy;
			adx_s1    <= dxh[tdir_pkg::HALF_W-1] ? tdir_pkg::ABS_W'(-dxh) : tdir_pkg::ABS_W'(dxh);
			ady_s1    <= dyh[tdir_pkg::HALF_W-1] ? tdir_pkg::ABS_W'(-dyh) : tdir_pkg::ABS_W'(dyh);
			x_neg_s1  <= dxh[tdir_pkg::HALF_W-1];
			z_pos_s1  <= dyh[tdir_pkg::HALF_W-1];
			status_s1 <= st_in;

			d2_s2 <= tdir_pkg::D2_W'(tdir_pkg::D2_W'(ddx_s1) * tdir_pkg::D2_W'(ddx_s1))
				+ tdir_pkg::D2_W'(tdir_pkg::D2_W'(ddy_s1) * tdir_pkg::D2_W'(ddy_s1));
			tag_s2.status <= status_s1;
			tag_s2.x_neg  <= x_neg_s1;
			tag_s2.z_pos  <= z_pos_s1;
			tag_s2.ax_mpp <= tdir_pkg::PROD_W'(adx_s1) * tdir_pkg::PROD_W'(cfg_eff.mm_per_pixel);
			tag_s2.az_mpp <= tdir_pkg::PROD_W'(ady_s1) * tdir_pkg::PROD_W'(cfg_eff.mm_per_pixel);
			tag_s2.mag    <= '0;
		end
	end

	tdir_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (vld_s2),
		.tag_i   (tag_s2),
		.v_i     (tdir_pkg::SQRT_W'({d2_s2, 16'd0})),
		.valid_o (sq_valid),
		.tag_o   (sq_tag),
		.root_o  (sq_root)
	);

	tdir_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (sq_valid),
		.tag_i   (sq_tag),
		.dist_i  (sq_root),
		.ratio_i (cfg_eff.depth_ratio),
		.valid_o (dv_valid),
		.tag_o   (dv_tag)
	);

	tdir_offset u_offset (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (dv_valid),
		.tag_i   (dv_tag),
		.cam_i   (cfg_eff.cam_mm),
		.valid_o (of_valid),
		.tag_o   (of_tag),
		.x_mag_o (of_x_mag),
		.z_mag_o (of_z_mag)
	);

	tdir_rotate u_rotate (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_i  (of_valid),
		.tag_i    (of_tag),
		.x_mag_i  (of_x_mag),
		.z_mag_i  (of_z_mag),
		.cfg_i    (cfg_eff),
		.valid_o  (out_valid),
		.status_o (status),
		.pos_x_o  (pos_x),
		.pos_y_o  (pos_y),
		.pos_z_o  (pos_z)
	);

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != tdir_pkg::ST_OK |-> pos_x == 0 && pos_y == 0 && pos_z == 0)
		else $error("failed status with nonzero position");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == tdir_pkg::ST_OK || status == tdir_pkg::ST_NO_DOTS ||
			status == tdir_pkg::ST_COINCIDE)
		else $error("undefined status code");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result held at the output");

endmodule
